// ===== rtl/oal_pkg.sv =====
// shared types and constants for the ordered array list engine
`default_nettype none
package oal_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int WORD_W    = 32;
  localparam int IDX_W     = 9;
  localparam int CAP_W     = 9;
  localparam int CNT_W     = 9;
  localparam int CMD_W     = 4;

  localparam logic [CAP_W-1:0]  CAP_RESET = 9'd256;
  localparam logic [WORD_W-1:0] FAIL_WORD = 32'hFFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 4'd0,
    CMD_INSERT  = 4'd1,
    CMD_DELETE  = 4'd2,
    CMD_GET     = 4'd3,
    CMD_SET     = 4'd4,
    CMD_MAX     = 4'd5,
    CMD_MIN     = 4'd6,
    CMD_SUM     = 4'd7,
    CMD_REVERSE = 4'd8
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/oal_reduce.sv =====
// one step of the max, min and sum reductions over words read from the store
`default_nettype none
module oal_reduce (
  input  oal_pkg::cmd_t                   op,
  input  logic                            first,
  input  logic signed [oal_pkg::WORD_W-1:0] acc,
  input  logic signed [oal_pkg::WORD_W-1:0] data,
  output logic signed [oal_pkg::WORD_W-1:0] acc_o
);
  import oal_pkg::*;

  always_comb begin
    acc_o = acc;
    if (first) begin
      // first word seeds every reduction, and is the word read by get and delete
      acc_o = data;
    end else begin
      case (op)
        CMD_MAX: if (data > acc) acc_o = data;
        CMD_MIN: if (data < acc) acc_o = data;
        CMD_SUM: acc_o = acc + data;
        default: acc_o = acc;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ordered_array_list_engine.sv =====
// top level of the ordered array list engine: control, element store and result register
`default_nettype none
// Ordered list of signed 32-bit words held in a DEPTH-entry synchronous memory.
// A command transaction is taken at a clock edge with start high and busy low;
// in_cmd, in_index and in_value are sampled there. Exactly one result follows:
// out_valid is high for one cycle with out_result, out_ok and out_count, and it
// is taken at the edge ending that cycle, since the receiver cannot stall.
// The capacity register is written through cfg_valid / cfg_ready / cfg_data;
// cfg_ready is low while busy is high or while a command is offered on start.
// Result timing, n being the list length at the command:
//   append, set, reverse of fewer than two words and rejected commands:
//     result in the cycle after start, busy stays low.
//   get, insert, delete, max, min and sum walk the store in S_WALK, then return to idle;
//     an insert at index n and a sum of an empty list walk nothing.
//   reverse swaps floor(n / 2) pairs of words in S_REV, then returns to idle.
// Each walk moves one element per cycle through the store's single read port
// and single write port; reverse needs two reads and two writes per pair.
// Reset (rst_n low at a clock edge) empties the list and sets capacity to 256;
// the store contents are not cleared and need no clearing pass.
// A new command may be taken while the previous result is still on the outputs.
module ordered_array_list_engine #(
  parameter int DEPTH = oal_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [oal_pkg::CMD_W-1:0]          in_cmd,
  input  logic [oal_pkg::IDX_W-1:0]          in_index,
  input  logic signed [oal_pkg::WORD_W-1:0]  in_value,
  output logic                               out_valid,
  output logic signed [oal_pkg::WORD_W-1:0]  out_result,
  output logic                               out_ok,
  output logic [oal_pkg::CNT_W-1:0]          out_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [oal_pkg::CAP_W-1:0]          cfg_data
);
  import oal_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > IDX_W) ? LW : IDX_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_REV  = 3'b100
  } state_t;

  logic [WORD_W-1:0] mem [DEPTH];

  state_t            state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [LW-1:0]     cnt_r, cnt_nxt;
  logic              vld_r, vld_nxt;
  logic [AW-1:0]     aptr_r, aptr_nxt;
  logic [WORD_W-1:0] rdata_r;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] tmp_r, tmp_nxt;
  logic [AW-1:0]     lo_r, lo_nxt, hi_r, hi_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_result_r, out_result_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [CW-1:0]     n_c, idx_c, lim_c;
  logic              room, idx_lt, idx_le, accept;
  logic [LW-1:0]     len_p1, len_m1;
  logic              go_walk;
  logic [WORD_W-1:0] red_acc;

  assign n_c    = CW'(len_r);
  assign idx_c  = CW'(in_index);
  assign lim_c  = (CW'(cap_r) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_r);
  assign room   = n_c < lim_c;
  assign idx_lt = idx_c < n_c;
  assign idx_le = idx_c <= n_c;
  assign accept = start && (state_r == S_IDLE);
  assign len_p1 = len_r + 1'b1;
  assign len_m1 = len_r - 1'b1;

  assign busy       = (state_r != S_IDLE);
  // a capacity write never shares an edge with a command transaction
  assign cfg_ready  = !busy && !start;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_ok     = out_ok_r;
  assign out_count  = out_count_r;

  oal_reduce u_reduce (
    .op    (cmd_r),
    .first (aptr_r == idx_r),
    .acc   (acc_r),
    .data  (rdata_r),
    .acc_o (red_acc)
  );

  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cap_r;
    len_nxt        = len_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    vld_nxt        = 1'b0;
    aptr_nxt       = aptr_r;
    acc_nxt        = acc_r;
    tmp_nxt        = tmp_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    ph_nxt         = ph_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    out_ok_nxt     = out_ok_r;
    out_count_nxt  = out_count_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    go_walk        = 1'b0;

    if (cfg_valid && cfg_ready) begin
      cap_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = FAIL_WORD;
          out_ok_nxt     = 1'b0;
          out_count_nxt  = CNT_W'(len_r);
          idx_nxt        = idx_c[AW-1:0];
          val_nxt        = in_value;
          acc_nxt        = '0;
          case (in_cmd)
            CMD_APPEND: begin
              if (room) begin
                wr_en          = 1'b1;
                wr_addr        = len_r[AW-1:0];
                wr_data        = in_value;
                len_nxt        = len_p1;
                out_result_nxt = '0;
                out_ok_nxt     = 1'b1;
                out_count_nxt  = CNT_W'(len_p1);
              end
            end
            CMD_INSERT: begin
              if (idx_le && room) begin
                go_walk = 1'b1;
                cnt_nxt = LW'(n_c - idx_c);
                ptr_nxt = len_m1[AW-1:0];
              end
            end
            CMD_DELETE: begin
              if (idx_lt) begin
                go_walk = 1'b1;
                cnt_nxt = LW'(n_c - idx_c);
                ptr_nxt = idx_c[AW-1:0];
              end
            end
            CMD_GET: begin
              if (idx_lt) begin
                go_walk = 1'b1;
                cnt_nxt = LW'(1);
                ptr_nxt = idx_c[AW-1:0];
              end
            end
            CMD_SET: begin
              if (idx_lt) begin
                wr_en          = 1'b1;
                wr_addr        = idx_c[AW-1:0];
                wr_data        = in_value;
                out_result_nxt = '0;
                out_ok_nxt     = 1'b1;
              end
            end
            CMD_MAX, CMD_MIN, CMD_SUM: begin
              // sum of an empty list still succeeds with zero
              if (len_r != '0 || in_cmd == CMD_SUM) begin
                go_walk = 1'b1;
                cnt_nxt = len_r;
                ptr_nxt = '0;
                idx_nxt = '0;
              end
            end
            CMD_REVERSE: begin
              if (len_r > LW'(1)) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_REV;
                lo_nxt        = '0;
                hi_nxt        = len_m1[AW-1:0];
                ph_nxt        = '0;
              end else begin
                out_result_nxt = '0;
                out_ok_nxt     = 1'b1;
              end
            end
            default: begin
              out_ok_nxt = 1'b0;
            end
          endcase
          if (go_walk) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_WALK;
            cmd_nxt       = cmd_t'(in_cmd);
          end
        end
      end

      S_WALK: begin
        if (cnt_r != '0) begin
          rd_en    = 1'b1;
          rd_addr  = ptr_r;
          ptr_nxt  = (cmd_r == CMD_INSERT) ? ptr_r - 1'b1 : ptr_r + 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
          vld_nxt  = 1'b1;
          aptr_nxt = ptr_r;
        end
        if (vld_r) begin
          acc_nxt = red_acc;
          if (cmd_r == CMD_INSERT) begin
            wr_en   = 1'b1;
            wr_addr = aptr_r + 1'b1;
            wr_data = rdata_r;
          end else if (cmd_r == CMD_DELETE && aptr_r != idx_r) begin
            wr_en   = 1'b1;
            wr_addr = aptr_r - 1'b1;
            wr_data = rdata_r;
          end
        end
        // all reads issued and the last word processed
        if (cnt_r == '0 && !vld_r) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = 1'b1;
          out_result_nxt = acc_r;
          out_count_nxt  = CNT_W'(len_r);
          if (cmd_r == CMD_INSERT) begin
            wr_en          = 1'b1;
            wr_addr        = idx_r;
            wr_data        = val_r;
            len_nxt        = len_p1;
            out_result_nxt = '0;
            out_count_nxt  = CNT_W'(len_p1);
          end else if (cmd_r == CMD_DELETE) begin
            len_nxt       = len_m1;
            out_count_nxt = CNT_W'(len_m1);
          end
        end
      end

      S_REV: begin
        ph_nxt = ph_r + 1'b1;
        case (ph_r)
          2'd0: begin
            rd_en   = 1'b1;
            rd_addr = lo_r;
          end
          2'd1: begin
            rd_en   = 1'b1;
            rd_addr = hi_r;
            tmp_nxt = rdata_r;
          end
          2'd2: begin
            wr_en   = 1'b1;
            wr_addr = lo_r;
            wr_data = rdata_r;
          end
          default: begin
            wr_en   = 1'b1;
            wr_addr = hi_r;
            wr_data = tmp_r;
            lo_nxt  = lo_r + 1'b1;
            hi_nxt  = hi_r - 1'b1;
            if (!((lo_r + 1'b1) < (hi_r - 1'b1))) begin
              state_nxt      = S_IDLE;
              out_valid_nxt  = 1'b1;
              out_result_nxt = '0;
              out_ok_nxt     = 1'b1;
              out_count_nxt  = CNT_W'(len_r);
            end
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      len_r       <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      len_r       <= len_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    ptr_r        <= ptr_nxt;
    cnt_r        <= cnt_nxt;
    aptr_r       <= aptr_nxt;
    acc_r        <= acc_nxt;
    tmp_r        <= tmp_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    ph_r         <= ph_nxt;
    out_result_r <= out_result_nxt;
    out_ok_r     <= out_ok_nxt;
    out_count_r  <= out_count_nxt;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(DEPTH))
    else $error("list length beyond store depth");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !out_valid)
    else $error("result strobe without a command");

  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_result == FAIL_WORD))
    else $error("rejected command without the failure word");

  a_port_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write of the same entry in one cycle");

endmodule
`default_nettype wire
